// ===== rtl/core/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte function of the frame decoder.
package htfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               temperature_crc_bad;
        logic               humidity_crc_bad;
    } out_item_t;

    // Raw words of one complete frame with their checksum verdicts.
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        temp_bad;
        logic        hum_bad;
    } frame_t;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } frame_pos_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/htfd_frame_asm.sv =====
// Frame assembly: byte position tracking, word building and CRC checking.
module htfd_frame_asm
    import htfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     frame_valid,
    input  logic     frame_ready,
    output frame_t   frame
);

    frame_pos_t  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_in, crc_step;
    logic [15:0] word_reg, word_next;
    logic [15:0] held_word_reg, held_word_next;
    logic        held_bad_reg, held_bad_next;
    logic        frame_valid_reg, frame_valid_next;
    frame_t      frame_reg, frame_next;
    logic        accept, emit;

    assign in_ready = !frame_valid_reg || frame_ready;
    assign accept   = in_valid && in_ready;

    // A start flag forces the byte to be the first of a new frame.
    always_comb
    begin
        if (in_item.frame_start)
            pos_eff = POS_T_HI;
        else
            pos_eff = pos_reg;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            unique case (pos_eff)
                POS_T_HI:  pos_next = POS_T_LO;
                POS_T_LO:  pos_next = POS_T_CRC;
                POS_T_CRC: pos_next = POS_H_HI;
                POS_H_HI:  pos_next = POS_H_LO;
                POS_H_LO:  pos_next = POS_H_CRC;
                POS_H_CRC: pos_next = POS_T_HI;
                default:   pos_next = POS_T_LO;
            endcase
        end
    end

    always_comb
    begin
        if (pos_eff == POS_T_HI || pos_eff == POS_H_HI)
            crc_in = CRC_INIT;
        else
            crc_in = crc_reg;
        crc_step = crc8_byte(crc_in, in_item.data_byte);
    end

    always_comb
    begin
        crc_next       = crc_reg;
        word_next      = word_reg;
        held_word_next = held_word_reg;
        held_bad_next  = held_bad_reg;
        emit           = 1'b0;
        frame_next     = frame_reg;
        if (accept)
        begin
            unique case (pos_eff)
                POS_T_HI, POS_H_HI:
                begin
                    crc_next  = crc_step;
                    word_next = {in_item.data_byte, 8'h00};
                end
                POS_T_LO, POS_H_LO:
                begin
                    crc_next  = crc_step;
                    word_next = {word_reg[15:8], in_item.data_byte};
                end
                POS_T_CRC:
                begin
                    held_word_next = word_reg;
                    held_bad_next  = (crc_reg != in_item.data_byte);
                    crc_next       = CRC_INIT;
                end
                POS_H_CRC:
                begin
                    crc_next   = CRC_INIT;
                    emit       = 1'b1;
                    frame_next = '{temp_word: held_word_reg,
                                   hum_word:  word_reg,
                                   temp_bad:  held_bad_reg,
                                   hum_bad:   (crc_reg != in_item.data_byte)};
                end
                default:
                begin
                    // Unreachable position: behaves as the first byte.
                    crc_next  = crc8_byte(CRC_INIT, in_item.data_byte);
                    word_next = {in_item.data_byte, 8'h00};
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
            frame_valid_next = 1'b1;
        else if (frame_ready)
            frame_valid_next = 1'b0;
        else
            frame_valid_next = frame_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_T_HI;
            crc_reg         <= CRC_INIT;
            word_reg        <= '0;
            held_word_reg   <= '0;
            held_bad_reg    <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            word_reg        <= word_next;
            held_word_reg   <= held_word_next;
            held_bad_reg    <= held_bad_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== rtl/core/htfd_scale.sv =====
// Conversion of raw words to hundredths: constant multiply, then divide by full scale.
module htfd_scale
    import htfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      frame_valid,
    output logic      frame_ready,
    input  frame_t    frame,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic        prod_valid_reg, prod_valid_next;
    logic [30:0] t_prod_reg, t_prod_next;
    logic [30:0] h_prod_reg, h_prod_next;
    logic        t_bad_reg, h_bad_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    logic        prod_ready, res_ready;
    logic [14:0] t_quot, h_quot;
    logic [15:0] t_signed;

    // Product divided by 65535. The estimate x >> 16 is never too large, and the
    // remainder it leaves stays below twice the divisor, so one correction suffices.
    function automatic logic [14:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        if (r >= FULL_SCALE)
            return q0 + 15'd1;
        else
            return q0;
    endfunction

    assign res_ready   = !out_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || res_ready;
    assign frame_ready = prod_ready;

    always_comb
    begin
        t_prod_next = 31'(TEMP_SPAN) * 31'(frame.temp_word);
        h_prod_next = 31'(HUM_SPAN) * 31'(frame.hum_word);
        if (frame_valid)
            prod_valid_next = 1'b1;
        else if (res_ready)
            prod_valid_next = 1'b0;
        else
            prod_valid_next = prod_valid_reg;
    end

    always_comb
    begin
        t_quot   = div_full_scale(t_prod_reg);
        h_quot   = div_full_scale(h_prod_reg);
        t_signed = {1'b0, t_quot} - TEMP_OFFSET;
        out_next = '{temperature_centi:   $signed(t_signed[14:0]),
                     humidity_centi:      h_quot[13:0],
                     temperature_crc_bad: t_bad_reg,
                     humidity_crc_bad:    h_bad_reg};
        if (prod_valid_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= prod_valid_next;
            if (res_ready)
                out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && frame_valid)
        begin
            t_prod_reg <= t_prod_next;
            h_prod_reg <= h_prod_next;
            t_bad_reg  <= frame.temp_bad;
            h_bad_reg  <= frame.hum_bad;
        end
        if (res_ready && prod_valid_reg)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/core/humidity_temperature_frame_decoder.sv =====
// Top level of the CRC-checked humidity and temperature frame decoder.
// The decoder takes one byte per cycle and never stalls its input unless the
// result side is blocked. A frame is six bytes: temperature word (high, low),
// its CRC-8 (poly 0x31, init 0xFF), humidity word (high, low), its CRC-8.
// A byte with frame_start set begins a new frame and drops any partial one.
// One result follows each sixth byte, with one register stage for frame
// assembly, one for the constant multiplications and one for the
// divide-by-65535 correction. The stages form a pipeline, so a result waiting
// on out_ready does not hold up bytes of the next frame. The converted values
// are given even when a CRC failure flag is set.
module humidity_temperature_frame_decoder
    import htfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic   frame_valid, frame_ready;
    frame_t frame;

    htfd_frame_asm u_frame_asm (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    htfd_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule
